@@ design/perspective_box_transform_macros.svh @@
// Assertion macros shared by the perspective box transform RTL.
`ifndef PERSPECTIVE_BOX_TRANSFORM_MACROS_SVH
`define PERSPECTIVE_BOX_TRANSFORM_MACROS_SVH

// Check a property while out of reset.
`define PBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define PBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/pbt_pkg.sv @@
// Shared constants and types for the perspective box transform.
package pbt_pkg;

  localparam int COORD_BITS = 12;
  localparam int CW         = COORD_BITS + 1;     // corner coordinate width
  localparam int COEF_W     = 32;
  localparam int PROD_W     = COEF_W + CW + 1;    // coef times signed corner
  localparam int NUM_W      = PROD_W + 2;         // sum of three terms
  localparam int FRAC_SHIFT = 10;                 // Q.20 over Q.30 alignment
  localparam int DVD_W      = NUM_W + FRAC_SHIFT; // dividend magnitude
  localparam int DSR_W      = NUM_W;              // divisor magnitude
  localparam int Q_W        = DVD_W + 1;          // signed quotient
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 64;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd5;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZDIV = 2'd2
  } status_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [DSR_W-1:0] dsr;
    logic             neg;
  } div_req_t;

endpackage

@@ design/pbt_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, signed result.
module pbt_div (
  input  logic                     clk,
  input  logic                     en,
  input  pbt_pkg::div_req_t        req,
  output logic signed [pbt_pkg::Q_W-1:0] quo
);
  import pbt_pkg::*;

  logic [DSR_W-1:0] rem [1:DVD_W];
  logic [DVD_W-1:0] dq  [1:DVD_W];
  logic [DSR_W-1:0] dsr [1:DVD_W];
  logic             neg [1:DVD_W];

  genvar i;
  generate
    for (i = 0; i < DVD_W; i++) begin : g_stage
      logic [DSR_W-1:0] rem_in;
      logic [DVD_W-1:0] dq_in;
      logic [DSR_W-1:0] dsr_in;
      logic             neg_in;
      logic [DSR_W:0]   sh;
      logic [DSR_W+1:0] tr;

      if (i == 0) begin : g_first
        assign rem_in = '0;
        assign dq_in  = req.dvd;
        assign dsr_in = req.dsr;
        assign neg_in = req.neg;
      end else begin : g_next
        assign rem_in = rem[i];
        assign dq_in  = dq[i];
        assign dsr_in = dsr[i];
        assign neg_in = neg[i];
      end

      assign sh = {rem_in, dq_in[DVD_W-1]};
      assign tr = {1'b0, sh} - {2'b00, dsr_in};

      // keep the shifted remainder when the trial subtract goes negative
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= tr[DSR_W+1] ? sh[DSR_W-1:0] : tr[DSR_W-1:0];
          dq[i+1]  <= {dq_in[DVD_W-2:0], ~tr[DSR_W+1]};
          dsr[i+1] <= dsr_in;
          neg[i+1] <= neg_in;
        end
      end
    end
  endgenerate

  logic signed [Q_W-1:0] mag;
  assign mag = signed'({1'b0, dq[DVD_W]});
  assign quo = neg[DVD_W] ? -mag : mag;

endmodule

@@ design/perspective_box_transform.sv @@
// Top level of the perspective box transform: homography of box corners to a bounding box.
//
// Usage:
//   A request on the input channel (in_valid/in_ready) carries one box
//   (box_x, box_y, box_width, box_height). Its four corners are mapped
//   through the 3x3 homography held in the configuration registers, each
//   divided by its own denominator and truncated, and the bounding box of
//   the four points plus the offset leaves on the output channel
//   (out_valid/out_ready) with a status code.
//   The pipeline runs through four stages of corner, multiply, sum and
//   sign prep, one stage per quotient bit in the eight parallel dividers,
//   then negate, two min/max stages and the offset/clamp output register.
//   One request enters per cycle while the pipeline is not held.
//   The whole pipeline advances together; when the receiver holds
//   out_ready low with a result waiting, every stage holds and in_ready
//   drops, so nothing is lost or repeated.
//   Reset empties the pipeline and loads the identity transform with zero
//   offset. Write configuration (cfg_write, cfg_index, cfg_data) only while
//   no request is in flight.
`include "perspective_box_transform_macros.svh"

module perspective_box_transform (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbt_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pbt_pkg::COORD_BITS-1:0]    box_x,
  input  logic [pbt_pkg::COORD_BITS-1:0]    box_y,
  input  logic [pbt_pkg::COORD_BITS-1:0]    box_width,
  input  logic [pbt_pkg::COORD_BITS-1:0]    box_height,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pbt_pkg::OUT_W-1:0]  out_x,
  output logic signed [pbt_pkg::OUT_W-1:0]  out_y,
  output logic [pbt_pkg::OUT_W-1:0]         out_width,
  output logic [pbt_pkg::OUT_W-1:0]         out_height,
  output logic [1:0]                        status
);
  import pbt_pkg::*;

  localparam int NSTG = DVD_W + 8;
  localparam int ZSTG = DVD_W + 4;

  // configuration registers
  logic [63:0] coef_a, coef_b, coef_c, coef_d;
  logic [31:0] coef_scale, offset_xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a     <= 64'd1048576;
      coef_b     <= 64'd0;
      coef_c     <= 64'd1048576;
      coef_d     <= 64'd0;
      coef_scale <= 32'd1073741824;
      offset_xy  <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEF_A: coef_a     <= cfg_data;
        REG_COEF_B: coef_b     <= cfg_data;
        REG_COEF_C: coef_c     <= cfg_data;
        REG_COEF_D: coef_d     <= cfg_data;
        REG_SCALE:  coef_scale <= cfg_data[31:0];
        REG_OFFSET: offset_xy  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic signed [COEF_W-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
  assign h00 = signed'(coef_a[31:0]);
  assign h01 = signed'(coef_a[63:32]);
  assign h02 = signed'(coef_b[31:0]);
  assign h10 = signed'(coef_b[63:32]);
  assign h11 = signed'(coef_c[31:0]);
  assign h12 = signed'(coef_c[63:32]);
  assign h20 = signed'(coef_d[31:0]);
  assign h21 = signed'(coef_d[63:32]);
  assign h22 = signed'(coef_scale);

  // pipeline control
  logic            adv;
  logic [NSTG-1:0] vld;
  logic [ZSTG-1:0] zsh;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // stage 1: corner coordinates
  logic [CW-1:0] cx [2];
  logic [CW-1:0] cy [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= CW'(box_x);
      cx[1] <= CW'(box_x) + CW'(box_width);
      cy[0] <= CW'(box_y);
      cy[1] <= CW'(box_y) + CW'(box_height);
    end
  end

  // stage 2: products, two distinct x and two distinct y values
  logic signed [PROD_W-1:0] p00 [2], p10 [2], p20 [2];
  logic signed [PROD_W-1:0] p01 [2], p11 [2], p21 [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        p00[j] <= h00 * signed'({1'b0, cx[j]});
        p10[j] <= h10 * signed'({1'b0, cx[j]});
        p20[j] <= h20 * signed'({1'b0, cx[j]});
        p01[j] <= h01 * signed'({1'b0, cy[j]});
        p11[j] <= h11 * signed'({1'b0, cy[j]});
        p21[j] <= h21 * signed'({1'b0, cy[j]});
      end
    end
  end

  // stage 3: numerators and denominators per corner
  logic signed [NUM_W-1:0] nx [4], ny [4], dn [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        nx[k] <= NUM_W'(p00[k%2]) + NUM_W'(p01[k/2]) + NUM_W'(h02);
        ny[k] <= NUM_W'(p10[k%2]) + NUM_W'(p11[k/2]) + NUM_W'(h12);
        dn[k] <= NUM_W'(p20[k%2]) + NUM_W'(p21[k/2]) + NUM_W'(h22);
      end
    end
  end

  // stage 4: magnitudes and quotient signs
  div_req_t req [8];
  logic     zdiv_any;

  always_comb begin
    zdiv_any = 1'b0;
    for (int k = 0; k < 4; k++) begin
      zdiv_any = zdiv_any || (dn[k] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        req[k].dvd   <= {(nx[k][NUM_W-1] ? NUM_W'(-nx[k]) : NUM_W'(nx[k])),
                         {FRAC_SHIFT{1'b0}}};
        req[k].dsr   <= dn[k][NUM_W-1] ? DSR_W'(-dn[k]) : DSR_W'(dn[k]);
        req[k].neg   <= nx[k][NUM_W-1] ^ dn[k][NUM_W-1];
        req[k+4].dvd <= {(ny[k][NUM_W-1] ? NUM_W'(-ny[k]) : NUM_W'(ny[k])),
                         {FRAC_SHIFT{1'b0}}};
        req[k+4].dsr <= dn[k][NUM_W-1] ? DSR_W'(-dn[k]) : DSR_W'(dn[k]);
        req[k+4].neg <= ny[k][NUM_W-1] ^ dn[k][NUM_W-1];
      end
      zsh <= {zsh[ZSTG-2:0], zdiv_any};
    end
  end

  // dividers: x quotients in lanes 0..3, y quotients in lanes 4..7
  logic signed [Q_W-1:0] quo [8];

  genvar g;
  generate
    for (g = 0; g < 8; g++) begin : g_div
      pbt_div u_div (
        .clk (clk),
        .en  (adv),
        .req (req[g]),
        .quo (quo[g])
      );
    end
  endgenerate

  // stage 5: register quotients
  logic signed [Q_W-1:0] q [8];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        q[k] <= quo[k];
      end
    end
  end

  // stage 6: pairwise min/max
  logic signed [Q_W-1:0] mnx [2], mxx [2], mny [2], mxy [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        mnx[j] <= (q[2*j] < q[2*j+1]) ? q[2*j] : q[2*j+1];
        mxx[j] <= (q[2*j] > q[2*j+1]) ? q[2*j] : q[2*j+1];
        mny[j] <= (q[2*j+4] < q[2*j+5]) ? q[2*j+4] : q[2*j+5];
        mxy[j] <= (q[2*j+4] > q[2*j+5]) ? q[2*j+4] : q[2*j+5];
      end
    end
  end

  // stage 7: final min/max
  logic signed [Q_W-1:0] minx, maxx, miny, maxy;

  always_ff @(posedge clk) begin
    if (adv) begin
      minx <= (mnx[0] < mnx[1]) ? mnx[0] : mnx[1];
      maxx <= (mxx[0] > mxx[1]) ? mxx[0] : mxx[1];
      miny <= (mny[0] < mny[1]) ? mny[0] : mny[1];
      maxy <= (mxy[0] > mxy[1]) ? mxy[0] : mxy[1];
    end
  end

  // stage 8: offset, extent, clamp into the output register
  localparam logic signed [Q_W:0] S_MIN = -(Q_W+1)'(32768);
  localparam logic signed [Q_W:0] S_MAX = (Q_W+1)'(32767);
  localparam logic signed [Q_W:0] U_MAX = (Q_W+1)'(65535);

  logic signed [Q_W:0] sx, sy, ew, eh;
  logic                sat_x, sat_y, sat_w, sat_h;
  logic signed [OUT_W-1:0] ox_c, oy_c;
  logic [OUT_W-1:0]        ew_c, eh_c;

  always_comb begin
    sx = (Q_W+1)'(minx) + (Q_W+1)'(signed'(offset_xy[15:0]));
    sy = (Q_W+1)'(miny) + (Q_W+1)'(signed'(offset_xy[31:16]));
    ew = (Q_W+1)'(maxx) - (Q_W+1)'(minx) + (Q_W+1)'(1);
    eh = (Q_W+1)'(maxy) - (Q_W+1)'(miny) + (Q_W+1)'(1);
    sat_x = (sx < S_MIN) || (sx > S_MAX);
    sat_y = (sy < S_MIN) || (sy > S_MAX);
    sat_w = ew > U_MAX;
    sat_h = eh > U_MAX;
    ox_c  = (sx < S_MIN) ? S_MIN[OUT_W-1:0] : (sx > S_MAX) ? S_MAX[OUT_W-1:0] : sx[OUT_W-1:0];
    oy_c  = (sy < S_MIN) ? S_MIN[OUT_W-1:0] : (sy > S_MAX) ? S_MAX[OUT_W-1:0] : sy[OUT_W-1:0];
    ew_c  = sat_w ? U_MAX[OUT_W-1:0] : ew[OUT_W-1:0];
    eh_c  = sat_h ? U_MAX[OUT_W-1:0] : eh[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zsh[ZSTG-1]) begin
        out_x      <= '0;
        out_y      <= '0;
        out_width  <= '0;
        out_height <= '0;
        status     <= ST_ZDIV;
      end else begin
        out_x      <= ox_c;
        out_y      <= oy_c;
        out_width  <= ew_c;
        out_height <= eh_c;
        status     <= (sat_x || sat_y || sat_w || sat_h) ? ST_SAT : ST_OK;
      end
    end
  end

  `PBT_ASSERT(a_accept_only_on_advance, (in_valid && in_ready) |-> (!out_valid || out_ready), "request accepted while pipeline held")
  `PBT_ASSERT(a_zdiv_zeroes_box, (out_valid && status == ST_ZDIV) |-> (out_x == '0 && out_y == '0 && out_width == '0 && out_height == '0), "zero divisor result not cleared")
  `PBT_ASSERT(a_extent_nonzero, (out_valid && status != ST_ZDIV) |-> (out_width != '0 && out_height != '0), "empty extent on a valid box")
  `PBT_ASSERT_ALWAYS(a_empty_after_reset, $past(rst) |-> !out_valid, "result present right after reset")

endmodule
